/* hw/rtl/saet_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saet_pkg: shared types and constants for the sorted alarm event table
// Field widths, mode/status/action codes, the entry format, and the command
// and status words between the controller and the datapath.
// ----------------------------------------------------------------------------
package saet_pkg;

    // Table depth and derived counter widths
    localparam int CAPACITY = 24;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Fixed field widths
    localparam int HOUR_W   = 4;
    localparam int MINUTE_W = 6;
    localparam int MODE_W   = 2;
    localparam int WDAY_W   = 3;
    localparam int MDAY_W   = 5;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 5;
    localparam int KEY_W    = 1 + HOUR_W + MINUTE_W;
    localparam int HM_W     = HOUR_W + MINUTE_W;

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_CHECK  = 1'b1;

    // Repeat modes
    localparam logic [MODE_W-1:0] MODE_ONCE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DAILY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WEEKLY = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_CHECK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUP      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RESTART  = 2'd3;

    // One stored event
    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic                pm;
        logic [MODE_W-1:0]   mode;
    } entry_t;

    // Input word
    typedef struct packed {
        logic                action;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic                pm;
        logic [MODE_W-1:0]   repeat_mode;
        logic [WDAY_W-1:0]   weekday;
        logic [MDAY_W-1:0]   month_day;
    } item_t;

    // Result word
    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic                event_valid;
        logic [HOUR_W-1:0]   event_hour;
        logic [MINUTE_W-1:0] event_minute;
        logic                event_pm;
        logic [MODE_W-1:0]   event_mode;
        logic                alarm_on;
        logic [COUNT_W-1:0]  table_fill;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic ins_scan;
        logic ins_shift;
        logic chk_fwd;
        logic chk_min;
        logic chk_fire;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_check;
        logic table_empty;
        logic idx_end;
        logic ins_less;
        logic ins_equal;
        logic shift_end;
        logic fwd_hit;
        logic out_free;
    } dp_sts_t;

    // Sort key: AM/PM, then hour, then minute
    function automatic logic [KEY_W-1:0] sort_key(input logic pm,
                                                  input logic [HOUR_W-1:0] hour,
                                                  input logic [MINUTE_W-1:0] minute);
        return {pm, hour, minute};
    endfunction

endpackage

/* hw/rtl/saet_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saet_req_if: input channel of the alarm table
// Valid/ready handshake carrying one insert or check word.
// ----------------------------------------------------------------------------
interface saet_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [3:0] hour;
    logic [5:0] minute;
    logic       pm;
    logic [1:0] repeat_mode;
    logic [2:0] weekday;
    logic [4:0] month_day;

    modport source (
        output valid, action, hour, minute, pm, repeat_mode, weekday, month_day,
        input  ready
    );

    modport sink (
        input  valid, action, hour, minute, pm, repeat_mode, weekday, month_day,
        output ready
    );
endinterface

/* hw/rtl/saet_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saet_rsp_if: result channel of the alarm table
// Valid/ready handshake carrying one result word per input word.
// ----------------------------------------------------------------------------
interface saet_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       event_valid;
    logic [3:0] event_hour;
    logic [5:0] event_minute;
    logic       event_pm;
    logic [1:0] event_mode;
    logic       alarm_on;
    logic [4:0] table_fill;

    modport source (
        output valid, status, event_valid, event_hour, event_minute, event_pm,
               event_mode, alarm_on, table_fill,
        input  ready
    );

    modport sink (
        input  valid, status, event_valid, event_hour, event_minute, event_pm,
               event_mode, alarm_on, table_fill,
        output ready
    );
endinterface

/* hw/rtl/saet_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saet_dp: alarm table datapath
// Register file of sorted entries, scan/shift counters, once-day latch,
// weekly date register, result assembly and the output register.
// ----------------------------------------------------------------------------
module saet_dp
    import saet_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  item_t             req_item,
    input  logic              rsp_ready,
    input  logic              cfg_we,
    input  logic [MDAY_W-1:0] cfg_wdata,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    output logic              out_valid,
    output result_t           out_word
);

    // Storage and control registers
    entry_t              store_reg [CAPACITY];
    logic [CNT_W-1:0]    count_reg;
    logic [WDAY_W-1:0]   once_day_reg;
    logic                once_open_reg;
    logic [MDAY_W-1:0]   wmd_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    k_reg;
    logic                restart_reg;
    logic                out_valid_reg;

    // Payload registers
    item_t               item_reg;
    entry_t              pick_reg;
    logic [HM_W:0]       best_reg;
    logic [STAT_W-1:0]   res_status_reg;
    logic                res_valid_reg;
    logic                res_fire_reg;
    result_t             out_reg;

    logic [IDX_W-1:0]    rd_ix;
    logic [IDX_W-1:0]    wr_ix;
    logic [IDX_W-1:0]    src_ix;
    logic [CNT_W-1:0]    k_dec;
    entry_t              rd_entry;
    entry_t              new_entry;
    logic [KEY_W-1:0]    rd_key;
    logic [KEY_W-1:0]    new_key;
    logic [HM_W:0]       rd_hm;
    logic                idx_end;
    logic                time_match;
    logic                fire;

    // Entry read at the scan index
    assign rd_ix    = idx_reg[IDX_W-1:0];
    assign rd_entry = (idx_reg < CNT_W'(CAPACITY)) ? store_reg[rd_ix] : '0;
    assign rd_key   = sort_key(rd_entry.pm, rd_entry.hour, rd_entry.minute);
    assign new_key  = sort_key(item_reg.pm, item_reg.hour, item_reg.minute);
    assign rd_hm    = {1'b0, rd_entry.hour, rd_entry.minute};
    assign idx_end  = (idx_reg == count_reg);

    assign new_entry.hour   = item_reg.hour;
    assign new_entry.minute = item_reg.minute;
    assign new_entry.pm     = item_reg.pm;
    assign new_entry.mode   = item_reg.repeat_mode;

    // Shift addresses
    assign k_dec  = k_reg - CNT_W'(1);
    assign wr_ix  = k_reg[IDX_W-1:0];
    assign src_ix = k_dec[IDX_W-1:0];

    // Status to controller
    always_comb
    begin
        sts.is_check    = (req_item.action == ACT_CHECK);
        sts.table_empty = (count_reg == '0);
        sts.idx_end     = idx_end;
        sts.ins_less    = !idx_end && (new_key < rd_key);
        sts.ins_equal   = !idx_end && (new_key == rd_key);
        sts.shift_end   = (k_reg == idx_reg);
        sts.fwd_hit     = !idx_end && (rd_key >= new_key);
        sts.out_free    = !out_valid_reg || rsp_ready;
    end

    // Alarm firing rule for the picked event
    assign time_match = (pick_reg.hour == item_reg.hour) &&
                        (pick_reg.minute == item_reg.minute) &&
                        (pick_reg.pm == item_reg.pm);

    always_comb
    begin
        unique case (pick_reg.mode)
            MODE_ONCE:   fire = time_match &&
                                (once_open_reg || (once_day_reg == item_reg.weekday));
            MODE_DAILY:  fire = time_match;
            MODE_WEEKLY: fire = time_match && (item_reg.month_day == wmd_reg);
            default:     fire = 1'b0;
        endcase
    end

    // Entry storage: shift up one slot per cycle, then place the new entry
    always_ff @(posedge clk)
    begin
        if (cmd.ins_shift)
        begin
            if (k_reg == idx_reg)
                store_reg[rd_ix] <= new_entry;
            else
                store_reg[wr_ix] <= store_reg[src_ix];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            once_day_reg  <= '0;
            once_open_reg <= 1'b1;
            wmd_reg       <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            restart_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                wmd_reg <= cfg_wdata;

            // new word: full table on insert starts over
            if (cmd.accept)
            begin
                idx_reg     <= '0;
                restart_reg <= 1'b0;
                if (req_item.action == ACT_INSERT && count_reg >= CNT_W'(CAPACITY))
                begin
                    count_reg   <= '0;
                    restart_reg <= 1'b1;
                end
            end

            // insert search
            if (cmd.ins_scan)
            begin
                if (idx_end || sts.ins_less)
                    k_reg <= count_reg;
                else if (!sts.ins_equal)
                    idx_reg <= idx_reg + CNT_W'(1);
            end

            // insert shift
            if (cmd.ins_shift)
            begin
                if (k_reg == idx_reg)
                    count_reg <= count_reg + CNT_W'(1);
                else
                    k_reg <= k_dec;
            end

            // forward search, then wraparound minimum search
            if (cmd.chk_fwd)
            begin
                if (idx_end)
                    idx_reg <= '0;
                else if (!sts.fwd_hit)
                    idx_reg <= idx_reg + CNT_W'(1);
            end

            if (cmd.chk_min && !idx_end)
                idx_reg <= idx_reg + CNT_W'(1);

            // once-day latch on first report of a once event
            if (cmd.chk_fire && pick_reg.mode == MODE_ONCE && once_open_reg)
            begin
                once_day_reg  <= item_reg.weekday;
                once_open_reg <= 1'b0;
            end

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload: item, pick, result and output word
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg       <= req_item;
            pick_reg       <= '0;
            best_reg       <= '1;
            res_status_reg <= STAT_CHECK;
            res_valid_reg  <= 1'b0;
            res_fire_reg   <= 1'b0;
        end

        if (cmd.ins_scan && sts.ins_equal)
            res_status_reg <= STAT_DUP;

        if (cmd.ins_shift && k_reg == idx_reg)
            res_status_reg <= restart_reg ? STAT_RESTART : STAT_INSERTED;

        if (cmd.chk_fwd && sts.fwd_hit)
            pick_reg <= rd_entry;

        if (cmd.chk_min && !idx_end && rd_hm < best_reg)
        begin
            best_reg <= rd_hm;
            pick_reg <= rd_entry;
        end

        if (cmd.chk_fire)
        begin
            res_valid_reg <= 1'b1;
            res_fire_reg  <= fire;
        end

        if (cmd.load_out)
        begin
            out_reg.status       <= res_status_reg;
            out_reg.event_valid  <= res_valid_reg;
            out_reg.event_hour   <= pick_reg.hour;
            out_reg.event_minute <= pick_reg.minute;
            out_reg.event_pm     <= pick_reg.pm;
            out_reg.event_mode   <= pick_reg.mode;
            out_reg.alarm_on     <= res_fire_reg;
            out_reg.table_fill   <= COUNT_W'(count_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

/* hw/rtl/saet_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saet_ctrl: alarm table sequencer
// Steps the datapath through search, shift and scan phases one entry per
// cycle and hands the finished word to the output register.
// ----------------------------------------------------------------------------
module saet_ctrl
    import saet_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  dp_sts_t sts,
    output logic    req_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_SHIFT,
        S_CHK_FWD,
        S_CHK_MIN,
        S_CHK_FIRE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Commands decoded from state
    always_comb
    begin
        cmd.accept    = (state_reg == S_IDLE) && req_valid;
        cmd.ins_scan  = (state_reg == S_INS_SCAN);
        cmd.ins_shift = (state_reg == S_INS_SHIFT);
        cmd.chk_fwd   = (state_reg == S_CHK_FWD);
        cmd.chk_min   = (state_reg == S_CHK_MIN);
        cmd.chk_fire  = (state_reg == S_CHK_FIRE);
        cmd.load_out  = (state_reg == S_DONE) && sts.out_free;
    end

    assign req_ready = (state_reg == S_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (!sts.is_check)
                        state_next = S_INS_SCAN;
                    else if (sts.table_empty)
                        state_next = S_DONE;
                    else
                        state_next = S_CHK_FWD;
                end
            end
            S_INS_SCAN:
            begin
                priority if (sts.ins_equal)
                    state_next = S_DONE;
                else if (sts.idx_end || sts.ins_less)
                    state_next = S_INS_SHIFT;
            end
            S_INS_SHIFT:
            begin
                if (sts.shift_end)
                    state_next = S_DONE;
            end
            S_CHK_FWD:
            begin
                priority if (sts.fwd_hit)
                    state_next = S_CHK_FIRE;
                else if (sts.idx_end)
                    state_next = S_CHK_MIN;
            end
            S_CHK_MIN:
            begin
                if (sts.idx_end)
                    state_next = S_CHK_FIRE;
            end
            S_CHK_FIRE:
                state_next = S_DONE;
            S_DONE:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* hw/rtl/sorted_alarm_event_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_alarm_event_table_core: sorted alarm event table
// Holds up to CAPACITY alarm events in time order; inserts events and reports
// the next event for a given current time, with its firing flag.
// ----------------------------------------------------------------------------
// Usage:
//   req  : valid/ready input word; action selects insert or check.
//   rsp  : valid/ready result word, exactly one per input word, in order.
//   cfg_we/cfg_wdata : writes the weekly match date; write only while idle.
// Phases (one table entry visited per cycle):
//   insert : accept, search, then shift unless a duplicate, then hand-off
//            to the output register (a full table restarts empty).
//   check  : accept, forward scan, minimum scan if the forward scan finds
//            nothing, fire, then hand-off; an empty table goes to hand-off.
//   One word is processed at a time; req.ready is high only while idle.
// The result sits in an output register, so the next word is accepted while
// an earlier result waits; if the receiver stalls past that, the finished
// word holds in the sequencer and req.ready stays low.
// Reset: table empty, once-day latch open, weekly date 0, no result pending.
// ----------------------------------------------------------------------------
module sorted_alarm_event_table_core
    import saet_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    saet_req_if.sink          req,
    saet_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [MDAY_W-1:0] cfg_wdata
);

    item_t   req_item;
    result_t out_word;
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    out_valid;
    logic    req_ready;

    // Pack input word
    always_comb
    begin
        req_item.action      = req.action;
        req_item.hour        = req.hour;
        req_item.minute      = req.minute;
        req_item.pm          = req.pm;
        req_item.repeat_mode = req.repeat_mode;
        req_item.weekday     = req.weekday;
        req_item.month_day   = req.month_day;
    end

    saet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .sts       (sts),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    saet_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .rsp_ready (rsp.ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

    // Drive channels
    assign req.ready        = req_ready;
    assign rsp.valid        = out_valid;
    assign rsp.status       = out_word.status;
    assign rsp.event_valid  = out_word.event_valid;
    assign rsp.event_hour   = out_word.event_hour;
    assign rsp.event_minute = out_word.event_minute;
    assign rsp.event_pm     = out_word.event_pm;
    assign rsp.event_mode   = out_word.event_mode;
    assign rsp.alarm_on     = out_word.alarm_on;
    assign rsp.table_fill   = out_word.table_fill;

endmodule

/* sim/sorted_alarm_event_table_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_alarm_event_table_core_test: self-checking bench for the alarm table
// Drives insert and check words through the request channel with random
// gaps, predicts every result word from a local copy of the sorted table,
// and compares each result field by field. The weekly match date is
// rewritten between phases while the block is idle. A directed opening
// covers the special cases, then random words with reused times drive the
// table through exact matches, duplicates and full-table restarts.
// ----------------------------------------------------------------------------
module sorted_alarm_event_table_core_test;
    import saet_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int PHASE_WORDS = 300;
    localparam int NUM_PHASES  = 5;
    localparam int HOLD_CYCLES = 400;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [MDAY_W-1:0] cfg_wdata;

    saet_req_if req_ch ();
    saet_rsp_if rsp_ch ();

    sorted_alarm_event_table_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Local copy of the table state
    entry_t            alarm_tab [CAPACITY];
    int                tab_cnt     = 0;
    logic [WDAY_W-1:0] once_day    = '0;
    logic              once_open   = 1'b1;
    logic [MDAY_W-1:0] weekly_date = '0;

    // Stimulus and checking bookkeeping
    item_t             pending_words [$];
    result_t           expected_results [$];
    logic [KEY_W-1:0]  recent_keys [$];
    item_t             cur_word;
    int                gap_left     = 0;
    int                stall_left   = 0;
    int                hold_left    = 0;
    int                hold_stage   = 0;
    int                results_seen = 0;
    int                err_cnt      = 0;
    int                cycle_cnt    = 0;
    wire               calm = (cycle_cnt % 5000) < 1500;

    function automatic logic [KEY_W-1:0] key_of(input entry_t e);
        return {e.pm, e.hour, e.minute};
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Apply one word to the local table and return the result it produces
    function automatic result_t predict_alarm(input item_t w);
        result_t          r;
        entry_t           e;
        logic [KEY_W-1:0] w_key;
        int               pos;
        int               pick;
        int               best;
        r     = '0;
        w_key = {w.pm, w.hour, w.minute};
        if (w.action == ACT_INSERT)
        begin
            r.status = STAT_INSERTED;
            if (tab_cnt >= CAPACITY)
            begin
                tab_cnt  = 0;
                r.status = STAT_RESTART;
            end
            pos = 0;
            while (pos < tab_cnt && key_of(alarm_tab[pos]) < w_key)
                pos++;
            if (pos < tab_cnt && key_of(alarm_tab[pos]) == w_key)
                r.status = STAT_DUP;
            else
            begin
                for (int k = tab_cnt; k > pos; k--)
                    alarm_tab[k] = alarm_tab[k - 1];
                e.hour         = w.hour;
                e.minute       = w.minute;
                e.pm           = w.pm;
                e.mode         = w.repeat_mode;
                alarm_tab[pos] = e;
                tab_cnt++;
            end
        end
        else if (tab_cnt > 0)
        begin
            // first entry at or after now, else smallest hour/minute
            pick = -1;
            for (int j = 0; j < tab_cnt; j++)
                if (pick < 0 && key_of(alarm_tab[j]) >= w_key)
                    pick = j;
            if (pick < 0)
            begin
                pick = 0;
                best = 'hFFFF;
                for (int j = 0; j < tab_cnt; j++)
                    if (int'({alarm_tab[j].hour, alarm_tab[j].minute}) < best)
                    begin
                        best = int'({alarm_tab[j].hour, alarm_tab[j].minute});
                        pick = j;
                    end
            end
            e              = alarm_tab[pick];
            r.event_valid  = 1'b1;
            r.event_hour   = e.hour;
            r.event_minute = e.minute;
            r.event_pm     = e.pm;
            r.event_mode   = e.mode;
            // once-day latch is taken on the first once event shown
            if (e.mode == MODE_ONCE && once_open)
            begin
                once_day  = w.weekday;
                once_open = 1'b0;
            end
            if (key_of(e) == w_key)
                case (e.mode)
                    MODE_ONCE:   r.alarm_on = (once_day == w.weekday);
                    MODE_DAILY:  r.alarm_on = 1'b1;
                    MODE_WEEKLY: r.alarm_on = (w.month_day == weekly_date);
                    default:     r.alarm_on = 1'b0;
                endcase
        end
        r.table_fill = COUNT_W'(tab_cnt);
        return r;
    endfunction

    function automatic item_t make_word(input logic act, input int hr, input int mn,
                                        input logic p, input logic [MODE_W-1:0] md,
                                        input int wd, input int dom);
        item_t w;
        w.action      = act;
        w.hour        = HOUR_W'(hr);
        w.minute      = MINUTE_W'(mn);
        w.pm          = p;
        w.repeat_mode = md;
        w.weekday     = WDAY_W'(wd);
        w.month_day   = MDAY_W'(dom);
        return w;
    endfunction

    // Random word; times are often reused so checks hit exactly and
    // some inserts come back as duplicates
    function automatic item_t rand_word();
        item_t w;
        w.action = ($urandom_range(0, 99) < 55) ? ACT_INSERT : ACT_CHECK;
        if ($urandom_range(0, 7) == 0)
            w.hour = HOUR_W'($urandom_range(0, 15));
        else
            w.hour = HOUR_W'($urandom_range(1, 12));
        if ($urandom_range(0, 7) == 0)
            w.minute = MINUTE_W'($urandom_range(0, 63));
        else
            w.minute = MINUTE_W'($urandom_range(0, 59));
        w.pm = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
            w.repeat_mode = MODE_SPARE;
        else
            w.repeat_mode = MODE_W'($urandom_range(0, 2));
        if ($urandom_range(0, 15) == 0)
            w.weekday = 3'd7;
        else
            w.weekday = WDAY_W'($urandom_range(0, 6));
        if ($urandom_range(0, 1) == 0)
            w.month_day = weekly_date;
        else
            w.month_day = MDAY_W'($urandom_range(0, 31));
        if (recent_keys.size() > 0 &&
            $urandom_range(0, 99) < ((w.action == ACT_CHECK) ? 50 : 10))
            {w.pm, w.hour, w.minute} = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        if (w.action == ACT_INSERT)
        begin
            recent_keys.push_back({w.pm, w.hour, w.minute});
            if (recent_keys.size() > CAPACITY)
                void'(recent_keys.pop_front());
        end
        return w;
    endfunction

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input int got_v, input int want_v);
        if (got_v != want_v)
            report($sformatf("result word %0d: %s is %0d, expected %0d",
                             results_seen, name, got_v, want_v));
    endtask

    // Register write; only called with nothing in flight
    task automatic set_weekly_date(input logic [MDAY_W-1:0] v);
        @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= v;
        weekly_date  = v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every word is sent and every result has come back
    task automatic wait_drained(input int settle);
        do
            @(negedge clk);
        while (pending_words.size() != 0 || req_ch.valid || expected_results.size() != 0);
        repeat (settle) @(posedge clk);
        @(negedge clk);
    endtask

    // Request driver: one word at a time from the pending queue
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            gap_left     <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_results.push_back(predict_alarm(cur_word));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left     <= gap_left - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    cur_word            = pending_words.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.action      <= cur_word.action;
                    req_ch.hour        <= cur_word.hour;
                    req_ch.minute      <= cur_word.minute;
                    req_ch.pm          <= cur_word.pm;
                    req_ch.repeat_mode <= cur_word.repeat_mode;
                    req_ch.weekday     <= cur_word.weekday;
                    req_ch.month_day   <= cur_word.month_day;
                    gap_left           <= calm ? 0 : pick_gap();
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus two long hold-offs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if ((hold_stage == 0 && results_seen >= 300) ||
                 (hold_stage == 1 && results_seen >= 1000))
        begin
            hold_stage   <= hold_stage + 1;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
                stall_left <= pick_gap();
        end
    end

    // Result monitor
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status       = rsp_ch.status;
            got.event_valid  = rsp_ch.event_valid;
            got.event_hour   = rsp_ch.event_hour;
            got.event_minute = rsp_ch.event_minute;
            got.event_pm     = rsp_ch.event_pm;
            got.event_mode   = rsp_ch.event_mode;
            got.alarm_on     = rsp_ch.alarm_on;
            got.table_fill   = rsp_ch.table_fill;
            if (expected_results.size() == 0)
                report($sformatf("result word %0d with none expected", results_seen));
            else
            begin
                want = expected_results.pop_front();
                check_field("status", int'(got.status), int'(want.status));
                check_field("event_valid", int'(got.event_valid), int'(want.event_valid));
                check_field("event_hour", int'(got.event_hour), int'(want.event_hour));
                check_field("event_minute", int'(got.event_minute),
                            int'(want.event_minute));
                check_field("event_pm", int'(got.event_pm), int'(want.event_pm));
                check_field("event_mode", int'(got.event_mode), int'(want.event_mode));
                check_field("alarm_on", int'(got.alarm_on), int'(want.alarm_on));
                check_field("table_fill", int'(got.table_fill), int'(want.table_fill));
            end
            results_seen <= results_seen + 1;
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("sorted_alarm_event_table_core test failed");
            $finish;
        end
    end

    // Sequence: reset, directed words, then random phases per date setting
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_INSERT;
        req_ch.hour        = '0;
        req_ch.minute      = '0;
        req_ch.pm          = 1'b0;
        req_ch.repeat_mode = MODE_ONCE;
        req_ch.weekday     = '0;
        req_ch.month_day   = '0;
        rsp_ch.ready       = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
            alarm_tab[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        set_weekly_date(5'd17);

        // check on an empty table
        pending_words.push_back(make_word(ACT_CHECK, 12, 59, 1'b1, MODE_ONCE, 6, 31));
        // once event: first report latches weekday 3 and fires, other day does not
        pending_words.push_back(make_word(ACT_INSERT, 7, 30, 1'b0, MODE_ONCE, 0, 0));
        pending_words.push_back(make_word(ACT_CHECK, 7, 30, 1'b0, MODE_DAILY, 3, 5));
        pending_words.push_back(make_word(ACT_CHECK, 7, 30, 1'b0, MODE_ONCE, 4, 5));
        // same time, other mode: duplicate
        pending_words.push_back(make_word(ACT_INSERT, 7, 30, 1'b0, MODE_DAILY, 0, 0));
        pending_words.push_back(make_word(ACT_INSERT, 12, 59, 1'b1, MODE_DAILY, 5, 2));
        pending_words.push_back(make_word(ACT_INSERT, 1, 0, 1'b0, MODE_WEEKLY, 1, 9));
        pending_words.push_back(make_word(ACT_INSERT, 11, 45, 1'b1, MODE_SPARE, 2, 3));
        pending_words.push_back(make_word(ACT_INSERT, 0, 0, 1'b0, MODE_DAILY, 7, 31));
        // daily fire, weekly fire on the date and not off it, spare mode silent
        pending_words.push_back(make_word(ACT_CHECK, 12, 59, 1'b1, MODE_ONCE, 2, 9));
        pending_words.push_back(make_word(ACT_CHECK, 1, 0, 1'b0, MODE_ONCE, 5, 17));
        pending_words.push_back(make_word(ACT_CHECK, 1, 0, 1'b0, MODE_WEEKLY, 5, 16));
        pending_words.push_back(make_word(ACT_CHECK, 11, 45, 1'b1, MODE_SPARE, 1, 17));
        // next event later in the table, then past the last one: wrap to smallest
        pending_words.push_back(make_word(ACT_CHECK, 12, 0, 1'b1, MODE_DAILY, 0, 0));
        pending_words.push_back(make_word(ACT_CHECK, 12, 63, 1'b1, MODE_DAILY, 0, 0));
        // out-of-range time at the top of the key space
        pending_words.push_back(make_word(ACT_INSERT, 15, 63, 1'b1, MODE_WEEKLY, 6, 30));
        pending_words.push_back(make_word(ACT_CHECK, 15, 63, 1'b1, MODE_ONCE, 7, 17));
        pending_words.push_back(make_word(ACT_CHECK, 0, 0, 1'b0, MODE_ONCE, 0, 31));
        // once event reported without a time match
        pending_words.push_back(make_word(ACT_CHECK, 2, 0, 1'b0, MODE_ONCE, 3, 17));
        wait_drained(4);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 0)
                set_weekly_date(5'd0);
            else if (p == 1)
                set_weekly_date(5'd31);
            else
                set_weekly_date(MDAY_W'($urandom_range(0, 31)));
            for (int n = 0; n < PHASE_WORDS; n++)
                pending_words.push_back(rand_word());
            wait_drained(60);
        end

        if (err_cnt == 0)
            $display("sorted_alarm_event_table_core test passed");
        else
            $display("sorted_alarm_event_table_core test failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/saet_pkg.sv
hw/rtl/saet_req_if.sv
hw/rtl/saet_rsp_if.sv
hw/rtl/saet_dp.sv
hw/rtl/saet_ctrl.sv
hw/rtl/sorted_alarm_event_table_core.sv
sim/sorted_alarm_event_table_core_test.sv
